// File: rtl/core/tdsa_pkg.sv
// Shared types, constants and helpers of the transmit descriptor slot allocator.
// No dependencies; every other file of the block refers to this package by scoped names.
package tdsa_pkg;

  localparam int MAX_SLOTS    = 64;
  localparam int BUFFER_BYTES = 2048;
  localparam int HEADER_BYTES = 12;

  localparam int SLOT_W  = 6;
  localparam int CNT_W   = 7;
  localparam int LEN_W   = 16;
  localparam int DLEN_W  = 12;
  localparam int ID_W    = 32;
  localparam int IDX_W   = 16;
  localparam int DROP_W  = 32;
  localparam int LOG_W   = 3;
  localparam int LOG_MAX = 6;

  localparam logic [LOG_W-1:0] LOG_RESET = LOG_W'(LOG_MAX);

  typedef enum logic [0:0] {
    OP_TRANSMIT = 1'b0,
    OP_COMPLETE = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_QUEUED    = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_RECLAIMED = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_operands;
    logic execute;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [DLEN_W-1:0] descriptor_length;
    logic [SLOT_W-1:0] ring_position;
    logic [IDX_W-1:0]  avail_index;
    logic [CNT_W-1:0]  free_slots;
    logic [DROP_W-1:0] dropped_count;
  } result_t;

  // Number of slots in use for a queue size log2; values above six act as six.
  function automatic logic [CNT_W-1:0] slots_in_use(input logic [LOG_W-1:0] lg);
    logic [LOG_W-1:0] lg_c;
    logic [CNT_W-1:0] n;
    lg_c = (lg > LOG_W'(LOG_MAX)) ? LOG_W'(LOG_MAX) : lg;
    n    = CNT_W'(1) << lg_c;
    return (n < CNT_W'(MAX_SLOTS)) ? n : CNT_W'(MAX_SLOTS);
  endfunction

endpackage

// File: rtl/core/tdsa_req_if.sv
// Request channel interface: valid/ready handshake with the request payload.
// Depends on tdsa_pkg for field widths.
interface tdsa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [tdsa_pkg::LEN_W-1:0]   frame_length;
  logic [tdsa_pkg::ID_W-1:0]    completion_id;

  modport source (output valid, output opcode, output frame_length, output completion_id,
                  input ready);
  modport sink   (input valid, input opcode, input frame_length, input completion_id,
                  output ready);
endinterface

// File: rtl/core/tdsa_rsp_if.sv
// Result channel interface: valid/ready handshake with the result payload.
// Depends on tdsa_pkg for field widths.
interface tdsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [tdsa_pkg::SLOT_W-1:0]   slot;
  logic [tdsa_pkg::DLEN_W-1:0]   descriptor_length;
  logic [tdsa_pkg::SLOT_W-1:0]   ring_position;
  logic [tdsa_pkg::IDX_W-1:0]    avail_index;
  logic [tdsa_pkg::CNT_W-1:0]    free_slots;
  logic [tdsa_pkg::DROP_W-1:0]   dropped_count;

  modport source (output valid, output status, output slot, output descriptor_length,
                  output ring_position, output avail_index, output free_slots,
                  output dropped_count, input ready);
  modport sink   (input valid, input status, input slot, input descriptor_length,
                  input ring_position, input avail_index, input free_slots,
                  input dropped_count, output ready);
endinterface

// File: rtl/core/tdsa_datapath.sv
// Datapath of the slot allocator: busy map, counters, operand and result registers.
// Depends on tdsa_pkg; driven by tdsa_ctrl through a dp_cmd_t command.
module tdsa_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tdsa_pkg::dp_cmd_t            cmd,
  input  logic                         in_opcode,
  input  logic [tdsa_pkg::LEN_W-1:0]   in_frame_length,
  input  logic [tdsa_pkg::ID_W-1:0]    in_completion_id,
  input  logic                         cfg_wr_en,
  input  logic [tdsa_pkg::LOG_W-1:0]   cfg_wr_data,
  output tdsa_pkg::result_t            result
);

  logic [tdsa_pkg::MAX_SLOTS-1:0] busy_map_r, busy_map_nxt;
  logic [tdsa_pkg::CNT_W-1:0]     free_count_r, free_count_nxt;
  logic [tdsa_pkg::IDX_W-1:0]     ring_index_r, ring_index_nxt;
  logic [tdsa_pkg::DROP_W-1:0]    drop_total_r, drop_total_nxt;
  logic [tdsa_pkg::LOG_W-1:0]     qlog_r;

  logic                           op_r;
  logic [tdsa_pkg::LEN_W-1:0]     flen_r;
  logic [tdsa_pkg::ID_W-1:0]      cid_r;

  tdsa_pkg::result_t              result_r, result_nxt;

  logic [tdsa_pkg::CNT_W-1:0]     size;
  logic [tdsa_pkg::SLOT_W-1:0]    size_mask;
  logic [tdsa_pkg::LEN_W:0]       total_len;
  logic                           found;
  logic [tdsa_pkg::SLOT_W-1:0]    free_idx;
  logic                           cid_in_range;
  logic [tdsa_pkg::SLOT_W-1:0]    cid_slot;

  assign size      = tdsa_pkg::slots_in_use(qlog_r);
  assign size_mask = tdsa_pkg::SLOT_W'(size - tdsa_pkg::CNT_W'(1));
  assign total_len = {1'b0, flen_r} + (tdsa_pkg::LEN_W+1)'(tdsa_pkg::HEADER_BYTES);
  assign cid_slot  = cid_r[tdsa_pkg::SLOT_W-1:0];
  assign cid_in_range = (cid_r[tdsa_pkg::ID_W-1:tdsa_pkg::CNT_W] == '0) &&
                        (cid_r[tdsa_pkg::CNT_W-1:0] < size);

  // Lowest free slot inside the active part of the map.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = tdsa_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
      if (!busy_map_r[i] && (tdsa_pkg::CNT_W'(i) < size)) begin
        found    = 1'b1;
        free_idx = tdsa_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    busy_map_nxt   = busy_map_r;
    free_count_nxt = free_count_r;
    ring_index_nxt = ring_index_r;
    drop_total_nxt = drop_total_r;
    result_nxt     = '0;

    if (op_r == tdsa_pkg::OP_TRANSMIT) begin
      if (total_len > (tdsa_pkg::LEN_W+1)'(tdsa_pkg::BUFFER_BYTES)) begin
        result_nxt.status = tdsa_pkg::ST_TOO_LONG;
        drop_total_nxt    = drop_total_r + tdsa_pkg::DROP_W'(1);
      end else if (free_count_r == '0 || !found) begin
        result_nxt.status = tdsa_pkg::ST_NO_SLOT;
        drop_total_nxt    = drop_total_r + tdsa_pkg::DROP_W'(1);
      end else begin
        result_nxt.status            = tdsa_pkg::ST_QUEUED;
        result_nxt.slot              = free_idx;
        result_nxt.descriptor_length = total_len[tdsa_pkg::DLEN_W-1:0];
        // The slot count is a power of two, so the ring modulo is a mask.
        result_nxt.ring_position     = ring_index_r[tdsa_pkg::SLOT_W-1:0] & size_mask;
        busy_map_nxt[free_idx]       = 1'b1;
        free_count_nxt               = free_count_r - tdsa_pkg::CNT_W'(1);
        ring_index_nxt               = ring_index_r + tdsa_pkg::IDX_W'(1);
      end
    end else begin
      if (cid_in_range && busy_map_r[cid_slot]) begin
        result_nxt.status      = tdsa_pkg::ST_RECLAIMED;
        busy_map_nxt[cid_slot] = 1'b0;
        free_count_nxt         = free_count_r + tdsa_pkg::CNT_W'(1);
      end else begin
        result_nxt.status = tdsa_pkg::ST_IGNORED;
      end
    end

    result_nxt.avail_index   = ring_index_nxt;
    result_nxt.free_slots    = free_count_nxt;
    result_nxt.dropped_count = drop_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_map_r   <= '0;
      free_count_r <= tdsa_pkg::slots_in_use(tdsa_pkg::LOG_RESET);
      ring_index_r <= '0;
      drop_total_r <= '0;
      qlog_r       <= tdsa_pkg::LOG_RESET;
    end else if (cfg_wr_en) begin
      qlog_r       <= cfg_wr_data;
      busy_map_r   <= '0;
      free_count_r <= tdsa_pkg::slots_in_use(cfg_wr_data);
    end else if (cmd.execute) begin
      busy_map_r   <= busy_map_nxt;
      free_count_r <= free_count_nxt;
      ring_index_r <= ring_index_nxt;
      drop_total_r <= drop_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_operands) begin
      op_r   <= in_opcode;
      flen_r <= in_frame_length;
      cid_r  <= in_completion_id;
    end
    if (cmd.execute) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// File: rtl/core/tdsa_ctrl.sv
// Controller of the slot allocator: sequences operand capture, execution and
// the result handshake. Depends on tdsa_pkg for the command type.
module tdsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tdsa_pkg::dp_cmd_t cmd
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  // A new transaction is taken once the result register is empty or being drained.
  assign in_ready          = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept            = in_valid && in_ready;
  assign cmd.load_operands = accept;
  assign cmd.execute       = (state_r == S_EXEC);
  assign out_valid         = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/tx_descriptor_slot_allocator_core.sv
// Top level of the transmit descriptor slot allocator for a split virtqueue.
// Depends on tdsa_pkg, tdsa_req_if, tdsa_rsp_if, tdsa_ctrl and tdsa_datapath.
//
//  channel   direction  transfers
//  in_chan   sink       opcode, frame_length, completion_id
//  out_chan  source     status, slot, descriptor_length, ring_position,
//                       avail_index, free_slots, dropped_count
//  cfg_*     write only queue_size_log2
//
// Each transaction first captures the operands; then the busy-map search and counter
// updates load the result register.
// A new transaction is accepted while the previous result is being taken, but not
// while the previous transaction is still executing.
// A held result stalls the input until out_chan.ready is seen.
// Sync reset frees all slots, zeroes ring and drop counts; no clearing pass is needed.
module tx_descriptor_slot_allocator_core (
  input  logic                       clk,
  input  logic                       rst_n,
  tdsa_req_if.sink                   in_chan,
  tdsa_rsp_if.source                 out_chan,
  input  logic                       cfg_wr_en,
  input  logic [tdsa_pkg::LOG_W-1:0] cfg_wr_data
);

  tdsa_pkg::dp_cmd_t cmd;
  tdsa_pkg::result_t result;

  tdsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  tdsa_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_chan.opcode),
    .in_frame_length  (in_chan.frame_length),
    .in_completion_id (in_chan.completion_id),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .result           (result)
  );

  assign out_chan.status            = result.status;
  assign out_chan.slot              = result.slot;
  assign out_chan.descriptor_length = result.descriptor_length;
  assign out_chan.ring_position     = result.ring_position;
  assign out_chan.avail_index       = result.avail_index;
  assign out_chan.free_slots        = result.free_slots;
  assign out_chan.dropped_count     = result.dropped_count;

endmodule
